// File: rtl/core/esfp_pkg.sv
// ----------------------------------------------------------------------------
// Environment sensor frame parser package
// Shared types, frame layout constants and divide-by-100 helpers.
// ----------------------------------------------------------------------------
package esfp_pkg;

    localparam int unsigned FRAME_LEN = 24;
    localparam int unsigned HDR_LEN   = 4;
    localparam int unsigned POS_W     = 5;

    localparam logic [7:0] HDR_SYNC  = 8'h5A;
    localparam logic [7:0] HDR_TYPE  = 8'h15;
    localparam logic [7:0] HDR_COUNT = 8'h04;

    localparam logic [POS_W-1:0] POS_LIGHT0 = 5'd4;
    localparam logic [POS_W-1:0] POS_LIGHT1 = 5'd5;
    localparam logic [POS_W-1:0] POS_LIGHT2 = 5'd6;
    localparam logic [POS_W-1:0] POS_LIGHT3 = 5'd7;
    localparam logic [POS_W-1:0] POS_TEMP0  = 5'd13;
    localparam logic [POS_W-1:0] POS_TEMP1  = 5'd14;
    localparam logic [POS_W-1:0] POS_PRESS0 = 5'd15;
    localparam logic [POS_W-1:0] POS_PRESS1 = 5'd16;
    localparam logic [POS_W-1:0] POS_PRESS2 = 5'd17;
    localparam logic [POS_W-1:0] POS_PRESS3 = 5'd18;
    localparam logic [POS_W-1:0] POS_HUMID0 = 5'd19;
    localparam logic [POS_W-1:0] POS_HUMID1 = 5'd20;
    localparam logic [POS_W-1:0] POS_ALT0   = 5'd21;
    localparam logic [POS_W-1:0] POS_ALT1   = 5'd22;
    localparam logic [POS_W-1:0] POS_LAST   = 5'd23;

    localparam logic [63:0] RECIP100_32 = 64'h0000_0000_51EB_851F;
    localparam logic [39:0] RECIP100_16 = 40'd83887;

    typedef struct packed {
        logic [31:0] light_raw;
        logic [15:0] temp_raw;
        logic [31:0] press_raw;
        logic [15:0] humid_raw;
        logic [15:0] alt_raw;
    } t_frame_fields;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = HDR_SYNC;
            2'd1: b = HDR_SYNC;
            2'd2: b = HDR_TYPE;
            2'd3: b = HDR_COUNT;
            default: b = HDR_SYNC;
        endcase
        return b;
    endfunction

    function automatic logic [25:0] div100_32(input logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * RECIP100_32;
        return p[62:37];
    endfunction

    function automatic logic [9:0] div100_16(input logic [15:0] x);
        logic [39:0] p;
        p = {24'd0, x} * RECIP100_16;
        return p[32:23];
    endfunction

endpackage

// File: rtl/core/esfp_frame_capture.sv
// ----------------------------------------------------------------------------
// Frame capture
// Tracks the byte position, checks the header and stores the used fields.
// ----------------------------------------------------------------------------
module esfp_frame_capture (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_beat,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_frame_done,
    output esfp_pkg::t_frame_fields o_fields
);
    import esfp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_frame_fields    r_fields;
    logic             hdr_bad;

    assign hdr_bad      = (r_pos < POS_W'(HDR_LEN)) && (i_rx_byte != hdr_byte(r_pos[1:0]));
    assign o_frame_done = i_beat && (r_pos == POS_LAST);
    assign o_fields     = r_fields;

    always_comb begin
        n_pos = r_pos;
        if (i_beat) begin
            if (hdr_bad || r_pos >= POS_LAST) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            case (r_pos)
                POS_LIGHT0: r_fields.light_raw[31:24] <= i_rx_byte;
                POS_LIGHT1: r_fields.light_raw[23:16] <= i_rx_byte;
                POS_LIGHT2: r_fields.light_raw[15:8]  <= i_rx_byte;
                POS_LIGHT3: r_fields.light_raw[7:0]   <= i_rx_byte;
                POS_TEMP0:  r_fields.temp_raw[15:8]   <= i_rx_byte;
                POS_TEMP1:  r_fields.temp_raw[7:0]    <= i_rx_byte;
                POS_PRESS0: r_fields.press_raw[31:24] <= i_rx_byte;
                POS_PRESS1: r_fields.press_raw[23:16] <= i_rx_byte;
                POS_PRESS2: r_fields.press_raw[15:8]  <= i_rx_byte;
                POS_PRESS3: r_fields.press_raw[7:0]   <= i_rx_byte;
                POS_HUMID0: r_fields.humid_raw[15:8]  <= i_rx_byte;
                POS_HUMID1: r_fields.humid_raw[7:0]   <= i_rx_byte;
                POS_ALT0:   r_fields.alt_raw[15:8]    <= i_rx_byte;
                POS_ALT1:   r_fields.alt_raw[7:0]     <= i_rx_byte;
                default:    r_fields <= r_fields;
            endcase
        end
    end

endmodule

// File: rtl/core/env_sensor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Environment sensor frame parser
// Takes one serial byte per beat, locks onto the 5A 5A 15 04 header and, on
// the 24th byte of a frame, delivers light, temperature, pressure and
// humidity divided by 100 together with the raw altitude. A byte can be
// accepted in every cycle unless input is stalled; the final byte of a
// frame moves the result through one reciprocal multiply per field into
// the output register, where it appears in the next cycle and is held
// until taken. Input is stalled whenever a finished result is still
// waiting and the output side is not ready in that cycle.
// ----------------------------------------------------------------------------
module env_sensor_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [25:0] o_light_level,
    output logic [9:0]  o_temperature,
    output logic [25:0] o_pressure,
    output logic [9:0]  o_humidity,
    output logic [15:0] o_altitude
);
    import esfp_pkg::*;

    logic          beat;
    logic          frame_done;
    t_frame_fields fields;
    logic          r_out_valid;
    logic [25:0]   r_light;
    logic [9:0]    r_temp;
    logic [25:0]   r_press;
    logic [9:0]    r_humid;
    logic [15:0]   r_alt;

    assign o_ready = !r_out_valid || i_ready;
    assign beat    = i_valid && o_ready;

    esfp_frame_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (beat),
        .i_rx_byte    (i_rx_byte),
        .o_frame_done (frame_done),
        .o_fields     (fields)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (frame_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_light <= div100_32(fields.light_raw);
            r_temp  <= div100_16(fields.temp_raw);
            r_press <= div100_32(fields.press_raw);
            r_humid <= div100_16(fields.humid_raw);
            r_alt   <= fields.alt_raw;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_light_level = r_light;
    assign o_temperature = r_temp;
    assign o_pressure    = r_press;
    assign o_humidity    = r_humid;
    assign o_altitude    = r_alt;

endmodule

// File: verif/env_sensor_frame_parser_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Environment sensor frame parser testbench
// Drives serial bytes into the parser one beat at a time and predicts every
// decoded reading from its own model of the header search and frame layout.
// Directed frames cover broken headers at each position and the extreme
// field values. Random streams then mix well-formed frames, broken headers
// and noise. Both sides idle at random, and one long output hold-off makes
// the parser stall its input.
// ----------------------------------------------------------------------------
module env_sensor_frame_parser_unit_tb;

    import esfp_pkg::*;

    localparam logic [31:0] SYNC_WORD = {HDR_SYNC, HDR_SYNC, HDR_TYPE, HDR_COUNT};
    localparam int unsigned TARGET_BYTES = 650;

    typedef struct packed {
        logic [25:0] light_level;
        logic [9:0]  temperature;
        logic [25:0] pressure;
        logic [9:0]  humidity;
        logic [15:0] altitude;
    } t_sensor_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [25:0] o_light_level;
    logic [9:0]  o_temperature;
    logic [25:0] o_pressure;
    logic [9:0]  o_humidity;
    logic [15:0] o_altitude;

    logic [4:0]      frame_pos;
    logic [7:0]      frame_buf [0:FRAME_LEN-1];
    t_sensor_reading pending_readings [$];
    int unsigned     kept_bytes;
    int unsigned     failures;
    bit              src_gaps_on;
    bit              sink_stalls_on;
    int unsigned     sink_hold_len;

    env_sensor_frame_parser_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_light_level (o_light_level),
        .o_temperature (o_temperature),
        .o_pressure    (o_pressure),
        .o_humidity    (o_humidity),
        .o_altitude    (o_altitude)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("env_sensor_frame_parser_unit regression: fail");
        $finish;
    end

    function automatic logic [7:0] header_at(input int unsigned idx);
        return SYNC_WORD[8*(3-idx) +: 8];
    endfunction

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic absorb_rx_byte(input logic [7:0] b);
        t_sensor_reading rd;
        logic [31:0]     light_raw;
        logic [31:0]     press_raw;
        logic [15:0]     temp_raw;
        logic [15:0]     humid_raw;
        if (frame_pos < HDR_LEN && b != header_at(frame_pos)) begin
            frame_pos = '0;
        end else begin
            frame_buf[frame_pos] = b;
            kept_bytes++;
            if (frame_pos == FRAME_LEN - 1) begin
                light_raw = {frame_buf[4], frame_buf[5], frame_buf[6], frame_buf[7]};
                temp_raw  = {frame_buf[13], frame_buf[14]};
                press_raw = {frame_buf[15], frame_buf[16], frame_buf[17], frame_buf[18]};
                humid_raw = {frame_buf[19], frame_buf[20]};
                rd.light_level = 26'(light_raw / 32'd100);
                rd.temperature = 10'(temp_raw / 16'd100);
                rd.pressure    = 26'(press_raw / 32'd100);
                rd.humidity    = 10'(humid_raw / 16'd100);
                rd.altitude    = {frame_buf[21], frame_buf[22]};
                pending_readings.push_back(rd);
                frame_pos = '0;
            end else begin
                frame_pos = frame_pos + 5'd1;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 2) == 0) begin
            gap = idle_len();
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_rx_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] fill, input bit random_body);
        for (int i = 0; i < HDR_LEN; i++) begin
            send_byte(header_at(i));
        end
        for (int i = HDR_LEN; i < FRAME_LEN; i++) begin
            send_byte(random_body ? rand_byte() : fill);
        end
    endtask

    task automatic send_broken_header();
        int unsigned n;
        logic [7:0]  b;
        n = $urandom_range(0, HDR_LEN - 1);
        for (int i = 0; i < n; i++) begin
            send_byte(header_at(i));
        end
        b = rand_byte();
        if (b == header_at(n)) begin
            b = ~b;
        end
        send_byte(b);
    endtask

    task automatic drain_readings();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_header_mismatch();
        send_byte(8'hAA);
        send_byte(HDR_SYNC);
        send_byte(8'h00);
        send_byte(HDR_SYNC);
        send_byte(HDR_SYNC);
        send_byte(8'hFF);
        send_byte(HDR_SYNC);
        send_byte(HDR_SYNC);
        send_byte(HDR_TYPE);
        send_byte(HDR_SYNC);
    endtask

    task automatic test_field_extremes();
        send_frame(8'hFF, 1'b0);
        send_frame(8'h00, 1'b0);
    endtask

    task automatic test_back_to_back();
        drain_readings();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (4) send_frame(8'h00, 1'b1);
        drain_readings();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        drain_readings();
        src_gaps_on   = 1'b0;
        sink_hold_len = 250;
        repeat (3) send_frame(8'h00, 1'b1);
        drain_readings();
        src_gaps_on   = 1'b1;
    endtask

    task automatic test_random_stream();
        int unsigned pick;
        while (kept_bytes < TARGET_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                send_frame(8'h00, 1'b1);
            end else if (pick == 8) begin
                send_broken_header();
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            end
            if ($urandom_range(0, 15) == 0) begin
                src_gaps_on    = ~src_gaps_on;
                sink_stalls_on = ~sink_stalls_on;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    initial begin
        i_ready <= 1'b0;
        forever begin
            if (sink_hold_len != 0) begin
                i_ready <= 1'b0;
                repeat (sink_hold_len) @(posedge i_clk);
                sink_hold_len = 0;
            end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sensor_reading want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                failures++;
                $display("%0t: unexpected reading, expected none, actual %0d %0d %0d %0d %0d",
                         $time, o_light_level, o_temperature, o_pressure, o_humidity,
                         o_altitude);
            end else begin
                want = pending_readings.pop_front();
                check_field("light_level", 32'(o_light_level), 32'(want.light_level));
                check_field("temperature", 32'(o_temperature), 32'(want.temperature));
                check_field("pressure", 32'(o_pressure), 32'(want.pressure));
                check_field("humidity", 32'(o_humidity), 32'(want.humidity));
                check_field("altitude", 32'(o_altitude), 32'(want.altitude));
            end
        end
    end

    initial begin
        failures       = 0;
        kept_bytes     = 0;
        frame_pos      = '0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        sink_hold_len  = 0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_mismatch();
        test_field_extremes();
        test_back_to_back();
        test_output_backpressure();
        test_random_stream();

        drain_readings();
        repeat (10) @(posedge i_clk);
        if (failures == 0 && pending_readings.size() == 0) begin
            $display("env_sensor_frame_parser_unit regression: pass");
        end else begin
            $display("env_sensor_frame_parser_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/esfp_pkg.sv
rtl/core/esfp_frame_capture.sv
rtl/core/env_sensor_frame_parser_unit.sv
verif/env_sensor_frame_parser_unit_tb.sv
